/* design/tdb_pkg.sv */
package tdb_pkg;

   localparam int SAMPLE_BITS = 22;
   localparam int CAL_SAMPLES = 10;
   localparam int SUM_W = SAMPLE_BITS + $clog2(CAL_SAMPLES);
   localparam int IDX_W = $clog2(CAL_SAMPLES + 1);
   localparam int RUN_W = 9;
   localparam int DEB_W = 8;

   localparam logic [DEB_W-1:0] DEB_RESET = DEB_W'(3);
   localparam logic [RUN_W-1:0] RUN_MAX = '1;
   localparam logic [IDX_W-1:0] CAL_LAST = IDX_W'(CAL_SAMPLES);
   localparam logic [SUM_W-1:0] CAL_MULT = SUM_W'(CAL_SAMPLES);

   typedef enum logic [2:0] {
      RPT_IDLE     = 3'b001,
      RPT_TOUCHED  = 3'b010,
      RPT_RELEASED = 3'b100
   } report_state_type;

   typedef struct packed {
      logic done;
      logic touched;
   } cal_status_type;

endpackage

/* design/tdb_cal.sv */
module tdb_cal (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                step,
   input  logic [tdb_pkg::SAMPLE_BITS-1:0]     raw_sample,
   output tdb_pkg::cal_status_type             status
);

   logic [tdb_pkg::IDX_W-1:0]       idx_ff, idx_in;
   logic [tdb_pkg::SUM_W-1:0]       sum_ff, sum_in;
   logic [tdb_pkg::SAMPLE_BITS:0]   raw_inc;
   logic [tdb_pkg::SAMPLE_BITS-1:0] half_up;
   logic [tdb_pkg::SUM_W-1:0]       scaled;
   logic                            done;

   // A sample exceeds twice floor(sum / N) exactly when N * ceil(sample / 2)
   // exceeds the sum, so the baseline never needs an actual divide.
   always_comb begin
      raw_inc = {1'b0, raw_sample} + (tdb_pkg::SAMPLE_BITS + 1)'(1);
      half_up = raw_inc[tdb_pkg::SAMPLE_BITS:1];
      scaled  = tdb_pkg::SUM_W'(half_up) * tdb_pkg::CAL_MULT;
      done    = (idx_ff == tdb_pkg::CAL_LAST);
      idx_in  = idx_ff;
      sum_in  = sum_ff;
      if (step && !done) begin
         idx_in = idx_ff + tdb_pkg::IDX_W'(1);
         sum_in = sum_ff + tdb_pkg::SUM_W'(raw_sample);
      end
   end

   assign status.done    = done;
   assign status.touched = (scaled > sum_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
         sum_ff <= '0;
      end else begin
         idx_ff <= idx_in;
         sum_ff <= sum_in;
      end
   end

endmodule

/* design/tdb_debounce.sv */
module tdb_debounce (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step,
   input  logic                          touched,
   input  logic [tdb_pkg::DEB_W-1:0]     debounce_count,
   output logic                          hit,
   output logic                          fire,
   output logic                          event_kind
);

   logic [tdb_pkg::RUN_W-1:0]  run_ff, run_in, run_base;
   logic                       last_ff, last_in;
   tdb_pkg::report_state_type  state_ff, state_in;
   logic                       suppress;
   logic                       match;

   always_comb begin
      run_base = (touched != last_ff) ? '0 : run_ff;
      run_in   = (run_base < tdb_pkg::RUN_MAX) ? run_base + tdb_pkg::RUN_W'(1) : run_base;
      match    = (run_in == {1'b0, debounce_count});
      case (state_ff)
         tdb_pkg::RPT_IDLE: begin
            suppress = !touched;
         end
         tdb_pkg::RPT_TOUCHED: begin
            suppress = touched;
         end
         tdb_pkg::RPT_RELEASED: begin
            suppress = !touched;
         end
         default: begin
            suppress = 1'b1;
         end
      endcase
      hit      = match && !suppress;
      fire     = step && hit;
      last_in  = last_ff;
      state_in = state_ff;
      // A suppressed event leaves the recorded level as it was.
      if (step && (!match || !suppress)) begin
         last_in = touched;
      end
      if (fire) begin
         state_in = touched ? tdb_pkg::RPT_TOUCHED : tdb_pkg::RPT_RELEASED;
      end
   end

   assign event_kind = touched;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff   <= '0;
         last_ff  <= 1'b0;
         state_ff <= tdb_pkg::RPT_IDLE;
      end else begin
         if (step) begin
            run_ff <= run_in;
         end
         last_ff  <= last_in;
         state_ff <= state_in;
      end
   end

endmodule

/* design/touch_detect_debounce_baseline_top.sv */
// Touch detector with baseline calibration and debounce.
// The request channel (req_valid, req_ready, req_raw_sample) takes one raw
// converter sample per request. The response channel (rsp_valid, rsp_ready,
// rsp_event_kind) delivers a touch (1) or release (0) event when one occurs;
// most requests produce no response.
// The csr channel writes the debounce count; it is always ready and should
// only be written while no request is in flight.
// A request is registered in the input register at acceptance and evaluated
// there; its event passes through the response register to the channel.
// One request is accepted every cycle unless a pending event stalls it; the
// compare and counter update between the two registers are combinational.
// After reset the debounce count is 3 and the first ten requests calibrate
// the baseline without producing responses.
// When the receiver stalls with an event pending, the block keeps accepting
// requests as long as they produce no event; a request that would produce
// one waits in the input register and req_ready drops until the response
// is taken.
module touch_detect_debounce_baseline_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [tdb_pkg::SAMPLE_BITS-1:0]      req_raw_sample,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_event_kind,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [tdb_pkg::DEB_W-1:0]            csr_debounce_count
);

   logic [tdb_pkg::DEB_W-1:0]       deb_ff;
   logic                            in_valid_ff;
   logic [tdb_pkg::SAMPLE_BITS-1:0] in_raw_ff;
   logic                            rsp_valid_ff;
   logic                            rsp_kind_ff;
   tdb_pkg::cal_status_type         cal_status;
   logic                            out_free;
   logic                            in_ready;
   logic                            advance;
   logic                            pass_step;
   logic                            hit;
   logic                            would_fire;
   logic                            fire;
   logic                            event_kind;

   assign would_fire = cal_status.done && hit;
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign advance    = in_valid_ff && (out_free || !would_fire);
   assign in_ready   = !in_valid_ff || advance;
   assign pass_step  = advance && cal_status.done;

   tdb_cal u_cal (
      .clock      (clock),
      .reset      (reset),
      .step       (advance),
      .raw_sample (in_raw_ff),
      .status     (cal_status)
   );

   tdb_debounce u_debounce (
      .clock          (clock),
      .reset          (reset),
      .step           (pass_step),
      .touched        (cal_status.touched),
      .debounce_count (deb_ff),
      .hit            (hit),
      .fire           (fire),
      .event_kind     (event_kind)
   );

   assign req_ready      = in_ready;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_event_kind = rsp_kind_ff;
   assign csr_ready      = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         deb_ff <= tdb_pkg::DEB_RESET;
      end else if (csr_valid) begin
         deb_ff <= csr_debounce_count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_valid && in_ready) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && in_ready) begin
         in_raw_ff <= req_raw_sample;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_kind_ff <= event_kind;
      end
   end

endmodule

/* tb/tdb_event_checker.sv */
module tdb_event_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_ready,
   input  logic [tdb_pkg::SAMPLE_BITS-1:0]   req_raw_sample,
   input  logic                              rsp_valid,
   input  logic                              rsp_ready,
   input  logic                              rsp_event_kind,
   input  logic                              csr_valid,
   input  logic                              csr_ready,
   input  logic [tdb_pkg::DEB_W-1:0]         csr_debounce_count,
   output int                                fail_count,
   output int                                pending_count
);

   import tdb_pkg::*;

   logic [DEB_W-1:0]       debounce;
   logic [IDX_W-1:0]       cal_count;
   logic [SUM_W-1:0]       cal_sum;
   logic [SAMPLE_BITS-1:0] baseline;
   logic                   last_level;
   logic [RUN_W-1:0]       run_len;
   report_state_type       shown_state;
   logic                   expected_events[$];
   int                     fails;

   function void detect_touch_event(input logic [SAMPLE_BITS-1:0] raw);
      logic touched;
      if (int'(cal_count) < CAL_SAMPLES) begin
         cal_sum = cal_sum + SUM_W'(raw);
         cal_count = cal_count + 1'b1;
         if (int'(cal_count) == CAL_SAMPLES) begin
            baseline = SAMPLE_BITS'(cal_sum / SUM_W'(CAL_SAMPLES));
         end
         return;
      end
      touched = {1'b0, raw} > {baseline, 1'b0};
      if (touched != last_level) begin
         run_len = '0;
      end
      if (run_len != RUN_MAX) begin
         run_len = run_len + 1'b1;
      end
      if (run_len == RUN_W'(debounce)) begin
         if (shown_state == RPT_IDLE && !touched) begin
            return;
         end
         if ((shown_state == RPT_TOUCHED && touched) ||
             (shown_state == RPT_RELEASED && !touched)) begin
            return;
         end
         shown_state = touched ? RPT_TOUCHED : RPT_RELEASED;
         last_level = touched;
         expected_events.push_back(touched);
         return;
      end
      last_level = touched;
   endfunction

   always @(posedge clock) begin
      logic want;
      if (reset) begin
         debounce = DEB_RESET;
         cal_count = '0;
         cal_sum = '0;
         baseline = '0;
         last_level = 1'b0;
         run_len = '0;
         shown_state = RPT_IDLE;
         expected_events.delete();
         fails = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_events.size() == 0) begin
               $error("event_kind: expected no response, actual %0d", rsp_event_kind);
               fails++;
            end else begin
               want = expected_events.pop_front();
               if (rsp_event_kind !== want) begin
                  $error("event_kind: expected %0d, actual %0d", want, rsp_event_kind);
                  fails++;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            debounce = csr_debounce_count;
         end
         if (req_valid && req_ready) begin
            detect_touch_event(req_raw_sample);
         end
      end
      fail_count <= fails;
      pending_count <= expected_events.size();
   end

endmodule

/* tb/touch_detect_debounce_baseline_top_tb.sv */
module touch_detect_debounce_baseline_top_tb;

   import tdb_pkg::*;

   localparam int unsigned SAMPLE_MAX = (1 << SAMPLE_BITS) - 1;
   localparam int unsigned CYCLE_LIMIT = 200000;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [SAMPLE_BITS-1:0] req_raw_sample = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic                   rsp_event_kind;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [DEB_W-1:0]       csr_debounce_count = '0;

   int          fail_count;
   int          pending_count;
   int unsigned cycle_count = 0;
   int unsigned threshold;
   int unsigned cal_total;
   int          req_quiet = 0;
   int          rsp_quiet = 0;

   touch_detect_debounce_baseline_top i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_raw_sample     (req_raw_sample),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_event_kind     (rsp_event_kind),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_debounce_count (csr_debounce_count)
   );

   tdb_event_checker i_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_raw_sample     (req_raw_sample),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_event_kind     (rsp_event_kind),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_debounce_count (csr_debounce_count),
      .fail_count         (fail_count),
      .pending_count      (pending_count)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Mostly random gaps, with occasional stretches of back-to-back traffic.
   function automatic int draw_gap(inout int quiet_left);
      if (quiet_left > 0) begin
         quiet_left--;
         return 0;
      end
      if ($urandom_range(0, 29) == 0) begin
         quiet_left = $urandom_range(10, 40);
      end
      return $urandom_range(0, 4);
   endfunction

   function automatic logic [SAMPLE_BITS-1:0] level_sample(input logic touched);
      if (touched) begin
         return SAMPLE_BITS'(($urandom_range(0, 15) == 0) ? SAMPLE_MAX :
                             $urandom_range(threshold + 1, SAMPLE_MAX));
      end
      return SAMPLE_BITS'(($urandom_range(0, 15) == 0) ? 0 : $urandom_range(0, threshold));
   endfunction

   task automatic send_sample(input logic [SAMPLE_BITS-1:0] raw);
      int gap;
      gap = draw_gap(req_quiet);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_raw_sample <= raw;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic hold_level(input logic touched, input int count);
      repeat (count) send_sample(level_sample(touched));
   endtask

   // Runs of one level with random content, broken up by the odd noisy request.
   task automatic run_levels(input int count, input int max_run);
      int sent;
      int len;
      logic touched;
      sent = 0;
      while (sent < count) begin
         touched = 1'($urandom_range(0, 1));
         len = $urandom_range(1, max_run);
         repeat (len) begin
            if ($urandom_range(0, 9) == 0) begin
               send_sample(SAMPLE_BITS'($urandom));
            end else begin
               send_sample(level_sample(touched));
            end
            sent++;
         end
      end
   endtask

   task automatic write_debounce(input logic [DEB_W-1:0] value);
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_valid <= 1'b1;
      csr_debounce_count <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      int gap;
      @(negedge reset);
      forever begin
         gap = draw_gap(rsp_quiet);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   initial begin
      logic [SAMPLE_BITS-1:0] raw;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Calibration with both extremes of the sample range.
      cal_total = 0;
      for (int i = 0; i < CAL_SAMPLES; i++) begin
         raw = SAMPLE_BITS'((i == 0) ? 0 : (i == 1) ? SAMPLE_MAX :
                            $urandom_range(0, 300000));
         cal_total += raw;
         send_sample(raw);
      end
      threshold = (cal_total / CAL_SAMPLES) * 2;

      // A release from idle is suppressed, then touch and release are reported.
      send_sample(SAMPLE_BITS'(threshold));
      send_sample('0);
      send_sample(SAMPLE_BITS'(threshold));
      send_sample(SAMPLE_BITS'($urandom_range(0, threshold)));
      send_sample(SAMPLE_BITS'(threshold + 1));
      send_sample(level_sample(1'b1));
      send_sample(SAMPLE_BITS'(threshold + 1));
      send_sample(SAMPLE_BITS'(SAMPLE_MAX));
      send_sample('0);
      send_sample(level_sample(1'b0));
      send_sample(SAMPLE_BITS'(threshold));
      // A run matching the already reported release is suppressed.
      send_sample(SAMPLE_BITS'(SAMPLE_MAX));
      send_sample('0);
      send_sample('0);
      send_sample(SAMPLE_BITS'(threshold));

      run_levels(80, 8);

      write_debounce(DEB_W'(1));
      run_levels(60, 4);

      write_debounce('0);
      run_levels(25, 6);

      // The touch run is long enough to reach the largest debounce count.
      write_debounce('1);
      hold_level(1'b1, 258);
      hold_level(1'b0, 20);

      write_debounce(DEB_W'($urandom_range(2, 6)));
      run_levels(45, 10);

      write_debounce(DEB_W'(2));
      run_levels(40, 5);

      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

/* sim.f */
design/tdb_pkg.sv
design/tdb_cal.sv
design/tdb_debounce.sv
design/touch_detect_debounce_baseline_top.sv
tb/tdb_event_checker.sv
tb/touch_detect_debounce_baseline_top_tb.sv
